>>> rtl/core/lfsa_pkg.sv
package lfsa_pkg;

  localparam int MAX_SLOTS   = 256;
  localparam int MAX_CLIENTS = 256;
  localparam int SLOT_W      = 9;
  localparam int CLIENT_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int GROUP_W     = 16;
  localparam int N_GROUPS    = MAX_SLOTS / GROUP_W;
  localparam int GRP_IDX_W   = $clog2(N_GROUPS);
  localparam int BIT_IDX_W   = $clog2(GROUP_W);
  localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd2;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic                cmd;
    logic [CLIENT_W-1:0] client_id;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_number;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic                vld;
    op_t                 op;
    logic [CLIENT_W-1:0] client_id;
  } front_req_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } back_res_t;

endpackage

>>> rtl/core/lfsa_ram.sv
module lfsa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/lfsa_front.sv
module lfsa_front
  import lfsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_data,
  output front_req_t req,
  input  logic       req_pop
);

  logic                cmd_r [2];
  logic [CLIENT_W-1:0] id_r  [2];
  logic                wp_r, wp_nxt;
  logic                rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign do_pop  = req_pop && (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_r[wp_r] <= in_data.cmd;
      id_r[wp_r]  <= in_data.client_id;
    end
  end

  // classify the head item for the engine
  always_comb begin
    req.vld       = (cnt_r != 2'd0);
    req.op        = cmd_r[rp_r] ? OP_RELEASE : OP_ALLOC;
    req.client_id = id_r[rp_r];
  end

endmodule

>>> rtl/core/lfsa_back.sv
module lfsa_back
  import lfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  front_req_t        req,
  output logic              req_pop,
  input  logic [1:0]        outq_level,
  output back_res_t         res,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_PICK
  } state_t;

  state_t                state_r;
  op_t                   op_r;
  logic [CLIENT_W-1:0]   id_r;
  logic [GRP_IDX_W-1:0]  grp_r;
  logic [MAX_SLOTS-1:0]  busy_r;
  logic [MAX_CLIENTS-1:0] cval_r;
  logic [SLOT_W-1:0]     cfg_r;
  logic                  res_vld_r;
  out_item_t             res_item_r;

  logic [MAX_SLOTS-1:0]  avail_mask;
  logic [MAX_SLOTS-1:0]  free_m;
  logic [N_GROUPS-1:0]   grp_free;
  logic [GRP_IDX_W-1:0]  grp_sel;
  logic                  grp_found;
  logic [GROUP_W-1:0]    grp_bits;
  logic [BIT_IDX_W-1:0]  bit_sel;
  logic [SLOT_W-1:0]     slot_pick;
  logic [SLOT_W-1:0]     ram_rdata;
  logic [SLOT_W-1:0]     held;
  logic [SLOT_IDX_W-1:0] held_m1;
  logic                  room;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail_mask[i] = (SLOT_W'(i) < cfg_r);
    end
    free_m = ~busy_r & avail_mask;
    for (int g = 0; g < N_GROUPS; g++) begin
      grp_free[g] = |free_m[g*GROUP_W +: GROUP_W];
    end
    grp_sel   = '0;
    grp_found = |grp_free;
    for (int g = N_GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_sel = GRP_IDX_W'(g);
      end
    end
    grp_bits = free_m[grp_r*GROUP_W +: GROUP_W];
    bit_sel  = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = BIT_IDX_W'(b);
      end
    end
    slot_pick = SLOT_W'({grp_r, bit_sel}) + SLOT_W'(1);
  end

  assign held    = cval_r[id_r] ? ram_rdata : '0;
  assign held_m1 = SLOT_IDX_W'(held - SLOT_W'(1));
  assign room    = (outq_level == 2'd0) || ((outq_level == 2'd1) && !res_vld_r);
  assign req_pop = (state_r == S_IDLE) && req.vld && room;

  lfsa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_CLIENTS)
  ) u_client_ram (
    .clk  (clk),
    .we   (state_r == S_PICK),
    .waddr(id_r),
    .wdata(slot_pick),
    .raddr(req.client_id),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      busy_r    <= '0;
      cval_r    <= '0;
      cfg_r     <= SLOT_W'(MAX_SLOTS);
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= 1'b0;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (req_pop) begin
            op_r    <= req.op;
            id_r    <= req.client_id;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          grp_r   <= grp_sel;
          state_r <= S_IDLE;
          if (op_r == OP_ALLOC) begin
            if (held != '0) begin
              res_vld_r  <= 1'b1;
              res_item_r <= '{slot_number: held, status: ST_OK};
            end else if (!grp_found) begin
              res_vld_r  <= 1'b1;
              res_item_r <= '{slot_number: '0, status: ST_FULL};
            end else begin
              state_r <= S_PICK;
            end
          end else begin
            res_vld_r <= 1'b1;
            if (held == '0) begin
              res_item_r <= '{slot_number: '0, status: ST_NOSLOT};
            end else begin
              busy_r[held_m1] <= 1'b0;
              cval_r[id_r]    <= 1'b0;
              res_item_r <= '{slot_number: held, status: ST_OK};
            end
          end
        end
        S_PICK: begin
          busy_r[{grp_r, bit_sel}] <= 1'b1;
          cval_r[id_r]             <= 1'b1;
          res_vld_r                <= 1'b1;
          res_item_r <= '{slot_number: slot_pick, status: ST_OK};
          state_r                  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res.vld  = res_vld_r;
  assign res.item = res_item_r;

endmodule

>>> rtl/core/lfsa_outq.sv
module lfsa_outq
  import lfsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  back_res_t res,
  output logic [1:0] level,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  out_item_t  mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign out_empty = (cnt_r == 2'd0);
  assign do_pop    = out_pop && !out_empty;
  assign level     = cnt_r;
  assign out_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = res.vld ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(res.vld) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      mem_r[wp_r] <= res.item;
    end
  end

endmodule

>>> rtl/core/lowest_free_slot_allocator.sv
// Lowest free slot allocator. An allocate item returns the lowest free slot in
// 1..slots_in_use to the client and marks it busy; a client already holding a
// slot gets that slot back unchanged, and a full pool answers slot 0, status 1.
// A release item frees the client's slot, or answers slot 0, status 2 if the
// client holds none. Items queue on the input side and results queue on the
// output side, two deep each. The engine takes one item at a time: a release
// or a repeated allocate needs only the registered read of the client table,
// while a fresh allocate follows it with a two-step search (first free 16-slot
// group, registered, then first free slot in it) over the occupancy bitmap.
// Each result is registered in the engine and then written to the output queue.
module lowest_free_slot_allocator
  import lfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata
);

  front_req_t req;
  logic       req_pop;
  back_res_t  res;
  logic [1:0] outq_level;

  lfsa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .req    (req),
    .req_pop(req_pop)
  );

  lfsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_pop   (req_pop),
    .outq_level(outq_level),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lfsa_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .level    (outq_level),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/lfsa_checker.sv
module lfsa_checker
  import lfsa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input out_item_t         out_data
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting item changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.status == ST_OK) || (out_data.status == ST_FULL) ||
                   (out_data.status == ST_NOSLOT))
    else $error("undefined status");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status != ST_OK) |-> out_data.slot_number == '0)
    else $error("failed item carries a slot");

  a_ok_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status == ST_OK) |->
      (out_data.slot_number != '0) && (out_data.slot_number <= SLOT_W'(MAX_SLOTS)))
    else $error("ok item with slot out of range");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (.*);
